[src/h264aus_pkg.sv]
// constants and helpers shared by the access unit scanner files
`default_nettype none
package h264aus_pkg;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

  localparam logic [7:0] SPS_PROFILE_CB   = 8'h42;
  localparam logic [7:0] SPS_CONSTRAINT_CB = 8'hc0;

  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    SPS_IDLE = 2'd0,
    SPS_PROF = 2'd1,
    SPS_CONS = 2'd2,
    SPS_LVL  = 2'd3
  } sps_phase_t;

  function automatic logic level_ok(input logic [7:0] v);
    level_ok = (v == 8'h1e) || (v == 8'h1f) || (v == 8'h20) || (v == 8'h28) ||
               (v == 8'h29) || (v == 8'h2a) || (v == 8'h32) || (v == 8'h33);
  endfunction

endpackage
`default_nettype wire

[src/h264_access_unit_scanner.sv]
// annex b access unit scanner: start codes, nal types and baseline sps profile
// the result word is registered and is valid in the cycle after the word marked last is taken
// throughput: one input word per cycle, limited only by the output register
// in_tready is low only while a result waits in the output register unclaimed
// reset: synchronous active-low rst_n clears all scan state and the output valid
`default_nettype none
module h264_access_unit_scanner
  import h264aus_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // data_byte[7:0]
  input  wire logic                   in_tlast,   // last
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // has_sps, has_pps, has_idr, profile_valid, profile_level[23:0], zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic [1:0]  zero_run_r, zero_run_nxt;
  logic        header_next_r, header_next_nxt;
  sps_phase_t  sps_phase_r, sps_phase_nxt;
  logic [15:0] sps_partial_r, sps_partial_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [23:0] latched_r, latched_nxt;
  logic        latched_valid_r, latched_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic        accept;
  logic [4:0]  nal_type;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign nal_type   = 5'(in_tdata & NAL_TYPE_MASK);

  always_comb begin
    zero_run_nxt      = zero_run_r;
    header_next_nxt   = header_next_r;
    sps_phase_nxt     = sps_phase_r;
    sps_partial_nxt   = sps_partial_r;
    seen_nxt          = seen_r;
    latched_nxt       = latched_r;
    latched_valid_nxt = latched_valid_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    out_data_nxt      = out_data_r;

    if (accept) begin
      if (header_next_r) begin
        if (nal_type == NAL_TYPE_SPS) begin
          seen_nxt[0]     = 1'b1;
          sps_phase_nxt   = SPS_PROF;
          sps_partial_nxt = 16'h0000;
        end else begin
          sps_phase_nxt = SPS_IDLE;
          if (nal_type == NAL_TYPE_PPS) begin
            seen_nxt[1] = 1'b1;
          end else if (nal_type == NAL_TYPE_IDR) begin
            seen_nxt[2] = 1'b1;
          end
        end
      end else begin
        case (sps_phase_r)
          SPS_PROF: begin
            if (in_tdata == SPS_PROFILE_CB) begin
              sps_partial_nxt = {8'h00, SPS_PROFILE_CB};
              sps_phase_nxt   = SPS_CONS;
            end else begin
              sps_phase_nxt = SPS_IDLE;
            end
          end
          SPS_CONS: begin
            if (in_tdata == SPS_CONSTRAINT_CB) begin
              sps_partial_nxt = {sps_partial_r[7:0], SPS_CONSTRAINT_CB};
              sps_phase_nxt   = SPS_LVL;
            end else begin
              sps_phase_nxt = SPS_IDLE;
            end
          end
          SPS_LVL: begin
            if (level_ok(in_tdata)) begin
              latched_nxt       = {sps_partial_r, in_tdata};
              latched_valid_nxt = 1'b1;
            end
            sps_phase_nxt = SPS_IDLE;
          end
          default: begin
            sps_phase_nxt = SPS_IDLE;
          end
        endcase
      end

      header_next_nxt = (in_tdata == 8'h01) && (zero_run_r == 2'd2);
      if (in_tdata == 8'h00) begin
        zero_run_nxt = (zero_run_r == 2'd2) ? zero_run_r : zero_run_r + 2'd1;
      end else begin
        zero_run_nxt = 2'd0;
      end

      if (in_tlast) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {4'h0,
                         (latched_valid_nxt ? latched_nxt : 24'h000000),
                         latched_valid_nxt, seen_nxt[2], seen_nxt[1], seen_nxt[0]};
        zero_run_nxt      = 2'd0;
        header_next_nxt   = 1'b0;
        sps_phase_nxt     = SPS_IDLE;
        sps_partial_nxt   = 16'h0000;
        seen_nxt          = 3'b000;
        latched_nxt       = 24'h000000;
        latched_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r      <= 2'd0;
      header_next_r   <= 1'b0;
      sps_phase_r     <= SPS_IDLE;
      sps_partial_r   <= 16'h0000;
      seen_r          <= 3'b000;
      latched_r       <= 24'h000000;
      latched_valid_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      zero_run_r      <= zero_run_nxt;
      header_next_r   <= header_next_nxt;
      sps_phase_r     <= sps_phase_nxt;
      sps_partial_r   <= sps_partial_nxt;
      seen_r          <= seen_nxt;
      latched_r       <= latched_nxt;
      latched_valid_r <= latched_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

[src/h264aus_checker.sv]
// port-level checks for the access unit scanner, bound to the top level
`default_nettype none
module h264aus_checker
  import h264aus_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tlast,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result word after last input word");

  a_profile_needs_sps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[0] && (out_tdata[27:12] == 16'h42c0))
    else $error("profile valid without a matching sps");

  a_invalid_profile_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> (out_tdata[27:4] == 24'h000000))
    else $error("profile level not zero when invalid");

endmodule

bind h264_access_unit_scanner h264aus_checker u_h264aus_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[bench/tb_h264_access_unit_scanner.sv]
// testbench for the annex b access unit scanner: directed table, then random access units
`timescale 1ns / 100ps
module tb_h264_access_unit_scanner;
  import h264aus_pkg::*;

  typedef struct packed {
    logic [3:0]  pad;
    logic [23:0] level;
    logic        pv;
    logic        idr;
    logic        pps;
    logic        sps;
  } au_summary_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_last;
    logic        typed;
    au_summary_t word;
  } au_row_t;

  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_ONE  = 8'h01;
  localparam logic [7:0] SUPPORTED_LEVELS [8] = '{
    8'h1e, 8'h1f, 8'h20, 8'h28, 8'h29, 8'h2a, 8'h32, 8'h33
  };
  localparam int RANDOM_BYTES = 2000;

  localparam au_summary_t NO_SUMMARY = '0;
  localparam au_summary_t SUM_SPS_L33 = '{4'h0, 24'h42c033, 1'b1, 1'b0, 1'b0, 1'b1};
  localparam au_summary_t SUM_PPS_IDR = '{4'h0, 24'h0, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam au_summary_t SUM_SPS_CUT = '{4'h0, 24'h0, 1'b0, 1'b0, 1'b0, 1'b1};

  localparam int DIRECTED_N = 28;
  localparam au_row_t DIRECTED [DIRECTED_N] = '{
    // junk before the first start code, sps with the highest level, ends on level byte
    '{8'hff, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h01, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h67, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h42, 1'b0, 1'b0, NO_SUMMARY},
    '{8'hc0, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h33, 1'b1, 1'b1, SUM_SPS_L33},
    // four-byte start code, pps, idr with high header bits, start code on last word
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h01, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h68, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h01, 1'b0, 1'b0, NO_SUMMARY},
    '{8'he5, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h01, 1'b1, 1'b1, SUM_PPS_IDR},
    // zero header byte starting the next start code, sps cut short
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h01, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h01, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h67, 1'b0, 1'b0, NO_SUMMARY},
    '{8'h42, 1'b1, 1'b1, SUM_SPS_CUT}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  h264_access_unit_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scan state of the predictor
  logic [1:0]  zero_cnt;
  logic        hdr_pending;
  sps_phase_t  sps_phase;
  logic [15:0] sps_bytes;
  logic        seen_sps, seen_pps, seen_idr;
  logic [23:0] prof_latch;
  logic        prof_ok;

  au_summary_t pending_summaries [$];
  logic [7:0]  unit_bytes [$];

  int errors = 0;
  int bytes_sent = 0;
  int units_sent = 0;
  int summaries_seen = 0;
  int profiles_seen = 0;
  int sps_units = 0;
  int pps_units = 0;
  int idr_units = 0;
  logic idle_on = 1'b0;
  logic stall_on = 1'b0;
  int stall_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic level_supported(input logic [7:0] v);
    logic hit;
    hit = 1'b0;
    foreach (SUPPORTED_LEVELS[i])
      if (SUPPORTED_LEVELS[i] == v) hit = 1'b1;
    return hit;
  endfunction

  task automatic clear_scan_state();
    zero_cnt = 2'd0;
    hdr_pending = 1'b0;
    sps_phase = SPS_IDLE;
    sps_bytes = 16'h0;
    seen_sps = 1'b0;
    seen_pps = 1'b0;
    seen_idr = 1'b0;
    prof_latch = 24'h0;
    prof_ok = 1'b0;
  endtask

  task automatic scan_au_byte(input logic [7:0] b, input logic is_last,
                              output logic emits, output au_summary_t summary);
    logic [7:0] masked;
    logic [4:0] nal_kind;
    masked = b & NAL_TYPE_MASK;
    nal_kind = masked[4:0];
    emits = 1'b0;
    summary = NO_SUMMARY;
    if (hdr_pending) begin
      hdr_pending = 1'b0;
      if (nal_kind == NAL_TYPE_SPS) begin
        seen_sps = 1'b1;
        sps_phase = SPS_PROF;
        sps_bytes = 16'h0;
      end else begin
        sps_phase = SPS_IDLE;
        if (nal_kind == NAL_TYPE_PPS) seen_pps = 1'b1;
        else if (nal_kind == NAL_TYPE_IDR) seen_idr = 1'b1;
      end
    end else begin
      case (sps_phase)
        SPS_PROF: begin
          if (b == SPS_PROFILE_CB) begin
            sps_bytes = {8'h00, b};
            sps_phase = SPS_CONS;
          end else sps_phase = SPS_IDLE;
        end
        SPS_CONS: begin
          if (b == SPS_CONSTRAINT_CB) begin
            sps_bytes = {sps_bytes[7:0], b};
            sps_phase = SPS_LVL;
          end else sps_phase = SPS_IDLE;
        end
        SPS_LVL: begin
          if (level_supported(b)) begin
            prof_latch = {sps_bytes, b};
            prof_ok = 1'b1;
          end
          sps_phase = SPS_IDLE;
        end
        default: ;
      endcase
    end
    if (b == START_ZERO) begin
      if (zero_cnt != 2'd2) zero_cnt = zero_cnt + 2'd1;
    end else begin
      if (b == START_ONE && zero_cnt == 2'd2) hdr_pending = 1'b1;
      zero_cnt = 2'd0;
    end
    if (is_last) begin
      emits = 1'b1;
      summary.sps = seen_sps;
      summary.pps = seen_pps;
      summary.idr = seen_idr;
      summary.pv = prof_ok;
      summary.level = prof_ok ? prof_latch : 24'h0;
      clear_scan_state();
    end
  endtask

  // drives one word, waits for its handshake, then predicts
  task automatic send_byte(input logic [7:0] b, input logic is_last,
                           input logic typed, input au_summary_t typed_word);
    int gap;
    logic emits;
    au_summary_t summary;
    gap = (idle_on && $urandom_range(0, 6) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    scan_au_byte(b, is_last, emits, summary);
    if (emits) begin
      units_sent++;
      pending_summaries.push_back(typed ? typed_word : summary);
    end
  endtask

  task automatic drain_summaries();
    in_tvalid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic push_start_code();
    int zeros;
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 2;
    repeat (zeros) unit_bytes.push_back(START_ZERO);
    unit_bytes.push_back(START_ONE);
  endtask

  // mostly well-formed nal sequences with random content, some noise and cut units
  task automatic compose_unit();
    int shape;
    int pick;
    int cut;
    logic [4:0] nal_kind;
    logic [2:0] hdr_top;
    unit_bytes.delete();
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 24))
        case ($urandom_range(0, 3))
          0: unit_bytes.push_back(START_ZERO);
          1: unit_bytes.push_back(START_ONE);
          default: unit_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) unit_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 4)) begin
        push_start_code();
        pick = $urandom_range(0, 9);
        if (pick < 4) nal_kind = NAL_TYPE_SPS;
        else if (pick < 6) nal_kind = NAL_TYPE_PPS;
        else if (pick < 8) nal_kind = NAL_TYPE_IDR;
        else nal_kind = 5'($urandom_range(0, 31));
        hdr_top = 3'($urandom_range(0, 7));
        unit_bytes.push_back({hdr_top, nal_kind});
        if (nal_kind == NAL_TYPE_SPS) begin
          pick = $urandom_range(0, 7);
          unit_bytes.push_back(pick == 0 ? 8'($urandom_range(0, 255)) : SPS_PROFILE_CB);
          unit_bytes.push_back(pick == 1 ? 8'($urandom_range(0, 255)) : SPS_CONSTRAINT_CB);
          unit_bytes.push_back(pick == 2 ? 8'($urandom_range(0, 255))
                                         : SUPPORTED_LEVELS[$urandom_range(0, 7)]);
        end
        repeat ($urandom_range(0, 8)) unit_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (shape == 1) begin
        cut = $urandom_range(1, unit_bytes.size());
        while (unit_bytes.size() > cut) void'(unit_bytes.pop_back());
      end
    end
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    au_summary_t got;
    au_summary_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = au_summary_t'(out_tdata);
      if (pending_summaries.size() == 0) begin
        report_mismatch("unexpected summary", out_tdata, 32'h0);
      end else begin
        want = pending_summaries.pop_front();
        summaries_seen++;
        if (want.pv) profiles_seen++;
        if (want.sps) sps_units++;
        if (want.pps) pps_units++;
        if (want.idr) idr_units++;
        if (got.sps !== want.sps)
          report_mismatch("has_sps", 32'(got.sps), 32'(want.sps));
        if (got.pps !== want.pps)
          report_mismatch("has_pps", 32'(got.pps), 32'(want.pps));
        if (got.idr !== want.idr)
          report_mismatch("has_idr", 32'(got.idr), 32'(want.idr));
        if (got.pv !== want.pv)
          report_mismatch("profile_valid", 32'(got.pv), 32'(want.pv));
        if (got.level !== want.level)
          report_mismatch("profile_level", 32'(got.level), 32'(want.level));
        if (got.pad !== want.pad)
          report_mismatch("pad bits", 32'(got.pad), 32'(want.pad));
      end
    end
  end

  initial begin
    int k;
    clear_scan_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stall_on = 1'b1;
    for (k = 0; k < DIRECTED_N; k++)
      send_byte(DIRECTED[k].data, DIRECTED[k].is_last, DIRECTED[k].typed, DIRECTED[k].word);
    drain_summaries();

    while (bytes_sent < DIRECTED_N + RANDOM_BYTES) begin
      if (bytes_sent > DIRECTED_N + (RANDOM_BYTES * 4) / 5) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      compose_unit();
      foreach (unit_bytes[i])
        send_byte(unit_bytes[i], i == unit_bytes.size() - 1, 1'b0, NO_SUMMARY);
      if (units_sent % 23 == 0) drain_summaries();
    end
    in_tvalid <= 1'b0;

    for (k = 0; k < 2000 && pending_summaries.size() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_summaries.size() != 0)
      report_mismatch("summaries never delivered", pending_summaries.size(), 32'h0);

    $display("scanned %0d words in %0d access units, %0d summaries checked",
             bytes_sent, units_sent, summaries_seen);
    $display("units with sps %0d, pps %0d, idr %0d, baseline profile latched %0d",
             sps_units, pps_units, idr_units, profiles_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
